@@ src/tdpe_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpe_pkg
// Shared widths, control codes and the microcode table of the trial division
// prime enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpe_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int CAND_WIDTH  = VALUE_WIDTH + 1;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int FIELD_WIDTH = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = 3;

   localparam logic [CAND_WIDTH-1:0]  FIRST_PRIME    = CAND_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR  = VALUE_WIDTH'(2);
   localparam logic [CAND_WIDTH-1:0]  FIRST_SQUARE   = CAND_WIDTH'(4);
   localparam logic [CNT_WIDTH-1:0]   LAST_BIT_COUNT = CNT_WIDTH'(VALUE_WIDTH - 1);

   // Register indexes on the configuration port.
   typedef enum logic {
      REG_UPPER_LIMIT = 1'b0,
      REG_UNUSED      = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      STEP_WAIT_REQ   = 3'd0,
      STEP_CHK_LIMIT  = 3'd1,
      STEP_CHK_SQUARE = 3'd2,
      STEP_DIVIDE     = 3'd3,
      STEP_CHK_REM    = 3'd4,
      STEP_EMIT_PRIME = 3'd5,
      STEP_EMIT_NONE  = 3'd6
   } step_type;

   typedef enum logic [2:0] {
      COND_REQ_VALID   = 3'd0,
      COND_LIMIT_OVER  = 3'd1,
      COND_SQUARE_OVER = 3'd2,
      COND_DIV_LAST    = 3'd3,
      COND_REM_ZERO    = 3'd4,
      COND_OUT_FREE    = 3'd5
   } cond_type;

   typedef enum logic [3:0] {
      OP_NONE         = 4'd0,
      OP_ACCEPT       = 4'd1,
      OP_INIT_DIVISOR = 4'd2,
      OP_INIT_DIV     = 4'd3,
      OP_DIV_STEP     = 4'd4,
      OP_NEXT_CAND    = 4'd5,
      OP_NEXT_DIVISOR = 4'd6,
      OP_EMIT_PRIME   = 4'd7,
      OP_EMIT_NONE    = 4'd8
   } op_type;

   typedef struct packed {
      cond_type cond;
      op_type   op_true;
      step_type jump_true;
      op_type   op_false;
      step_type jump_false;
   } ctrl_word_type;

   // Condition flags from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic limit_over;
      logic square_over;
      logic div_last;
      logic rem_zero;
      logic out_free;
   } flags_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      op_type op;
      logic   idle;
   } ctrl_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{COND_REQ_VALID, OP_NONE, STEP_WAIT_REQ, OP_NONE, STEP_WAIT_REQ};
      unique case (step)
         STEP_WAIT_REQ:
            w = '{COND_REQ_VALID, OP_ACCEPT, STEP_CHK_LIMIT, OP_NONE, STEP_WAIT_REQ};
         STEP_CHK_LIMIT:
            w = '{COND_LIMIT_OVER, OP_NONE, STEP_EMIT_NONE,
                  OP_INIT_DIVISOR, STEP_CHK_SQUARE};
         STEP_CHK_SQUARE:
            w = '{COND_SQUARE_OVER, OP_NONE, STEP_EMIT_PRIME,
                  OP_INIT_DIV, STEP_DIVIDE};
         STEP_DIVIDE:
            w = '{COND_DIV_LAST, OP_DIV_STEP, STEP_CHK_REM, OP_DIV_STEP, STEP_DIVIDE};
         STEP_CHK_REM:
            w = '{COND_REM_ZERO, OP_NEXT_CAND, STEP_CHK_LIMIT,
                  OP_NEXT_DIVISOR, STEP_CHK_SQUARE};
         STEP_EMIT_PRIME:
            w = '{COND_OUT_FREE, OP_EMIT_PRIME, STEP_WAIT_REQ,
                  OP_NONE, STEP_EMIT_PRIME};
         STEP_EMIT_NONE:
            w = '{COND_OUT_FREE, OP_EMIT_NONE, STEP_WAIT_REQ, OP_NONE, STEP_EMIT_NONE};
         default:
            w = '{COND_REQ_VALID, OP_NONE, STEP_WAIT_REQ, OP_NONE, STEP_WAIT_REQ};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ src/tdpe_seq.sv @@
// ----------------------------------------------------------------------------
// tdpe_seq
// Microcode sequencer: step counter, control table and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpe_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tdpe_pkg::flags_type flags,
   output tdpe_pkg::ctrl_type       ctrl
);

   tdpe_pkg::step_type      step_ff;
   tdpe_pkg::step_type      step_in;
   tdpe_pkg::ctrl_word_type word;
   logic                    cond_met;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tdpe_pkg::STEP_WAIT_REQ;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = tdpe_pkg::ucode_rom(step_ff);
      unique case (word.cond)
         tdpe_pkg::COND_REQ_VALID:   cond_met = flags.req_valid;
         tdpe_pkg::COND_LIMIT_OVER:  cond_met = flags.limit_over;
         tdpe_pkg::COND_SQUARE_OVER: cond_met = flags.square_over;
         tdpe_pkg::COND_DIV_LAST:    cond_met = flags.div_last;
         tdpe_pkg::COND_REM_ZERO:    cond_met = flags.rem_zero;
         tdpe_pkg::COND_OUT_FREE:    cond_met = flags.out_free;
         default:                    cond_met = 1'b0;
      endcase
      step_in   = cond_met ? word.jump_true : word.jump_false;
      ctrl.op   = cond_met ? word.op_true : word.op_false;
      ctrl.idle = (step_ff == tdpe_pkg::STEP_WAIT_REQ);
   end

endmodule

`default_nettype wire

@@ src/trial_division_prime_enumerator.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_enumerator
// Returns the primes up to a configured limit, one per request word, by trial
// division with a bit-serial remainder unit under microcode control.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_restart
// rsp       out        rsp_valid/rsp_stall  rsp_prime_value, rsp_found
// csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// A request tries candidates in turn and, for each one, divisors up to the
// square root of the candidate; the bit-serial remainder loop works out one
// quotient bit per cycle for each divisor tried.
// One request is in work at a time; req_stall is high until it finishes.
// Reset clears the limit to zero, the next candidate to two and the result
// valid flag; no clearing pass is needed. A stalled result holds in its register.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_enumerator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_restart,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [tdpe_pkg::FIELD_WIDTH-1:0]         rsp_prime_value,
   output logic                                     rsp_found,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tdpe_pkg::ADDR_WIDTH-1:0]     paddr,
   input  wire logic [tdpe_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [tdpe_pkg::DATA_WIDTH-1:0]          prdata,
   output logic                                     pready
);

   localparam int W = tdpe_pkg::VALUE_WIDTH;
   localparam int C = tdpe_pkg::CAND_WIDTH;

   tdpe_pkg::flags_type flags;
   tdpe_pkg::ctrl_type  ctrl;

   logic [W-1:0]                    limit_ff;
   logic [C-1:0]                    cand_ff, cand_in;
   logic [W-1:0]                    divisor_ff, divisor_in;
   logic [C-1:0]                    square_ff, square_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quot_ff, quot_in;
   logic [tdpe_pkg::CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tdpe_pkg::FIELD_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [W:0]                      rem_shift;
   logic                            csr_write;

   tdpe_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite
                      && (paddr[2] == tdpe_pkg::REG_UPPER_LIMIT);
   assign prdata    = (paddr[2] == tdpe_pkg::REG_UPPER_LIMIT)
                      ? tdpe_pkg::DATA_WIDTH'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_write) begin
         limit_ff <= W'(pwdata[tdpe_pkg::FIELD_WIDTH-1:0]);
      end
   end

   assign req_stall       = !ctrl.idle;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;

   assign rem_shift = {rem_ff, quot_ff[W-1]};

   always_comb begin
      flags.req_valid   = req_valid;
      flags.limit_over  = cand_ff > {1'b0, limit_ff};
      flags.square_over = square_ff > cand_ff;
      flags.div_last    = (cnt_ff == '0);
      flags.rem_zero    = (rem_ff == '0);
      flags.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cand_in      = cand_ff;
      divisor_in   = divisor_ff;
      square_in    = square_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (ctrl.op)
         tdpe_pkg::OP_ACCEPT: begin
            if (req_restart) begin
               cand_in = tdpe_pkg::FIRST_PRIME;
            end
         end
         tdpe_pkg::OP_INIT_DIVISOR: begin
            divisor_in = tdpe_pkg::FIRST_DIVISOR;
            square_in  = tdpe_pkg::FIRST_SQUARE;
         end
         tdpe_pkg::OP_INIT_DIV: begin
            rem_in  = '0;
            quot_in = cand_ff[W-1:0];
            cnt_in  = tdpe_pkg::LAST_BIT_COUNT;
         end
         tdpe_pkg::OP_DIV_STEP: begin
            // Restoring step: subtract the divisor whenever it fits.
            if (rem_shift >= {1'b0, divisor_ff}) begin
               rem_in = W'(rem_shift - {1'b0, divisor_ff});
            end else begin
               rem_in = rem_shift[W-1:0];
            end
            quot_in = {quot_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
         end
         tdpe_pkg::OP_NEXT_CAND: begin
            cand_in = cand_ff + 1'b1;
         end
         tdpe_pkg::OP_NEXT_DIVISOR: begin
            // (d + 1)^2 = d^2 + 2d + 1
            divisor_in = divisor_ff + 1'b1;
            square_in  = square_ff + {divisor_ff, 1'b0} + 1'b1;
         end
         tdpe_pkg::OP_EMIT_PRIME: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = tdpe_pkg::FIELD_WIDTH'(cand_ff[W-1:0]);
            rsp_found_in = 1'b1;
            cand_in      = cand_ff + 1'b1;
         end
         tdpe_pkg::OP_EMIT_NONE: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_found_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff      <= tdpe_pkg::FIRST_PRIME;
         rsp_valid_ff <= 1'b0;
      end else begin
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff   <= divisor_in;
      square_ff    <= square_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
   end

endmodule

`default_nettype wire
